FILE: sv/rpn_stack_evaluator_defines.svh
// ----------------------------------------------------------------------------
// RPN stack evaluator assertion macros
// Shared shorthand for the concurrent checks of the evaluator.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_EVALUATOR_DEFINES_SVH
`define RPN_STACK_EVALUATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPN_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RPN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/rpn_pkg.sv
// ----------------------------------------------------------------------------
// RPN stack evaluator package
// Field widths, item codes, status codes and the controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

	localparam int MODE_W   = 2;
	localparam int OP_W     = 2;
	localparam int VALUE_W  = 32;
	localparam int DEPTH_W  = 8;
	localparam int STATUS_W = 3;

	localparam int DEF_STACK_DEPTH = 128;
	localparam int DEF_WORD_BITS   = 32;

	typedef logic [MODE_W-1:0]   mode_t;
	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam mode_t MODE_PUSH = 2'd0;
	localparam mode_t MODE_OPER = 2'd1;
	localparam mode_t MODE_END  = 2'd2;

	localparam op_t OP_ADD = 2'd0;
	localparam op_t OP_SUB = 2'd1;
	localparam op_t OP_MUL = 2'd2;
	localparam op_t OP_DIV = 2'd3;

	localparam status_t ST_OK    = 3'd0;
	localparam status_t ST_UNDER = 3'd1;
	localparam status_t ST_OVER  = 3'd2;
	localparam status_t ST_DIVZ  = 3'd3;
	localparam status_t ST_EMPTY = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic cap_item;
		logic unit_start;
		logic commit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_unit;
		logic unit_done;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: sv/rpn_stack_evaluator.sv
// ----------------------------------------------------------------------------
// RPN stack evaluator
// Postfix expression evaluator taking one parsed token per item.
// ----------------------------------------------------------------------------
// Push, add, subtract, end and no-op items, and operators refused for underflow or
// a zero divisor, are captured and then committed in the execute state; multiply and
// divide start the bit-serial multiply/divide unit, wait for it, then commit at finish.
// One item is worked at a time: a new item is taken only once the last is committed.
// arst_n clears the depth, the sticky status and the handshake state at once;
// the stack memory is not cleared, as only entries below the depth are read.
`default_nettype none

module rpn_stack_evaluator #(
	parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH,
	parameter int WORD_BITS   = rpn_pkg::DEF_WORD_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               item_valid,
	output logic                                    item_ready,
	input  wire rpn_pkg::mode_t                     mode,
	input  wire logic signed [rpn_pkg::VALUE_W-1:0] value,
	input  wire rpn_pkg::op_t                       arith_op,
	output logic                                    result_valid,
	input  wire logic                               result_ready,
	output logic signed [rpn_pkg::VALUE_W-1:0]      top_value,
	output logic [rpn_pkg::DEPTH_W-1:0]             depth,
	output rpn_pkg::status_t                        status,
	output logic                                    is_final
);
	import rpn_pkg::*;

	// The controller steps each item through capture, execute and, for
	// multiply and divide, an iterative phase. It only accepts a new item
	// once the previous one has been committed to the result register, but
	// a committed result may still be waiting for the consumer while the
	// next item is taken in.
	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	rpn_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	// The datapath keeps the top of the stack in a register and the entries
	// beneath it in a single-port-write memory. The entry just below the top
	// is read every cycle into a register, so an operator item finds both of
	// its operands ready in the cycle after it is accepted. Errors are sticky:
	// the first nonzero status stays until an end item clears the stack.
	rpn_dpath #(
		.STACK_DEPTH(STACK_DEPTH),
		.WORD_BITS  (WORD_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.mode     (mode),
		.value    (value),
		.arith_op (arith_op),
		.top_value(top_value),
		.depth    (depth),
		.status   (status),
		.is_final (is_final)
	);

endmodule

`default_nettype wire

FILE: sv/rpn_muldiv.sv
// ----------------------------------------------------------------------------
// RPN multiply/divide unit
// Shift-and-add multiplier and restoring divider sharing one set of
// registers, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_muldiv #(
	parameter int WORD_BITS = rpn_pkg::DEF_WORD_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 is_div,
	input  wire logic [WORD_BITS-1:0] opa,
	input  wire logic [WORD_BITS-1:0] opb,
	output logic                      done,
	output logic [WORD_BITS-1:0]      result
);
	import rpn_pkg::*;

	localparam int CNT_W = $clog2(WORD_BITS);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 is_div_q;
	logic                 neg_q;
	logic [WORD_BITS-1:0] x_q;
	logic [WORD_BITS-1:0] y_q;
	logic [WORD_BITS-1:0] z_q;
	logic [WORD_BITS:0]   shifted;
	logic [WORD_BITS:0]   diff;

	function automatic logic [WORD_BITS-1:0] magnitude(input logic [WORD_BITS-1:0] w);
		magnitude = w[WORD_BITS-1] ? ('0 - w) : w;
	endfunction

	// Restoring step: bring down the next dividend bit and try the subtract.
	assign shifted = {x_q, z_q[WORD_BITS-1]};
	assign diff    = shifted - {1'b0, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(WORD_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			is_div_q <= is_div;
			neg_q    <= opa[WORD_BITS-1] ^ opb[WORD_BITS-1];
			x_q      <= '0;
			if (is_div) begin
				y_q <= magnitude(opb);
				z_q <= magnitude(opa);
			end else begin
				y_q <= opa;
				z_q <= opb;
			end
		end else if (busy_q) begin
			if (is_div_q) begin
				if (!diff[WORD_BITS]) begin
					x_q <= diff[WORD_BITS-1:0];
				end else begin
					x_q <= shifted[WORD_BITS-1:0];
				end
				z_q <= {z_q[WORD_BITS-2:0], ~diff[WORD_BITS]};
			end else begin
				if (z_q[0]) begin
					x_q <= x_q + y_q;
				end
				y_q <= {y_q[WORD_BITS-2:0], 1'b0};
				z_q <= {1'b0, z_q[WORD_BITS-1:1]};
			end
		end
	end

	assign done   = done_q;
	assign result = is_div_q ? (neg_q ? ('0 - z_q) : z_q) : x_q;

endmodule

`default_nettype wire

FILE: sv/rpn_dpath.sv
// ----------------------------------------------------------------------------
// RPN stack evaluator datapath
// Top-of-stack register, stack memory for the entries below it, depth and
// sticky status, add/subtract, the multiply/divide unit and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_dpath #(
	parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH,
	parameter int WORD_BITS   = rpn_pkg::DEF_WORD_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire rpn_pkg::ctrl_cmd_t                   cmd,
	output rpn_pkg::dp_stat_t                         stat,
	input  wire rpn_pkg::mode_t                       mode,
	input  wire logic signed [rpn_pkg::VALUE_W-1:0]   value,
	input  wire rpn_pkg::op_t                         arith_op,
	output logic signed [rpn_pkg::VALUE_W-1:0]        top_value,
	output logic [rpn_pkg::DEPTH_W-1:0]               depth,
	output rpn_pkg::status_t                          status,
	output logic                                      is_final
);
	import rpn_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	mode_t                mode_q;
	op_t                  op_q;
	logic [WORD_BITS-1:0] word_q;
	logic [CW-1:0]        count_q;
	status_t              err_q;
	logic [WORD_BITS-1:0] top_q;
	logic [WORD_BITS-1:0] below_q;
	logic [WORD_BITS-1:0] stack_mem [STACK_DEPTH];

	logic [VALUE_W-1:0]   top_value_q;
	logic [DEPTH_W-1:0]   depth_q;
	status_t              status_q;
	logic                 is_final_q;

	logic [2*VALUE_W-1:0]         value_ext;
	logic [CW-1:0]                rd_ptr;
	logic [CW-1:0]                wr_ptr;
	logic                         is_push;
	logic                         is_oper;
	logic                         is_end;
	logic                         full;
	logic                         empty;
	logic                         has_two;
	logic                         divz;
	logic                         op_ok;
	logic                         wr_en;
	status_t                      code_c;
	status_t                      err_nx;
	logic [WORD_BITS-1:0]         alu_res;
	logic [WORD_BITS-1:0]         unit_res;
	logic                         unit_done;
	logic [CW-1:0]                count_nx;
	logic [WORD_BITS-1:0]         top_nx;
	logic [WORD_BITS-1:0]         rep_top;
	logic [WORD_BITS+VALUE_W-1:0] top_wide;
	logic [CW+DEPTH_W-1:0]        depth_wide;

	// The operand is sign-extended and then cut to the word width.
	assign value_ext = {{VALUE_W{value[VALUE_W-1]}}, value};

	always_ff @(posedge clk) begin
		if (cmd.cap_item) begin
			mode_q <= mode;
			op_q   <= arith_op;
			word_q <= value_ext[WORD_BITS-1:0];
		end
	end

	// The top sits in top_q; the memory holds entries 0 .. count-2.
	assign rd_ptr = count_q - CW'(2);
	assign wr_ptr = count_q - CW'(1);

	assign is_push = (mode_q == MODE_PUSH);
	assign is_oper = (mode_q == MODE_OPER);
	assign is_end  = (mode_q == MODE_END);
	assign full    = (count_q == CW'(STACK_DEPTH));
	assign empty   = (count_q == '0);
	assign has_two = (count_q >= CW'(2));
	assign divz    = (top_q == '0);
	assign op_ok   = is_oper && has_two && !((op_q == OP_DIV) && divz);

	assign stat.need_unit = is_oper && has_two &&
		((op_q == OP_MUL) || ((op_q == OP_DIV) && !divz));
	assign stat.unit_done = unit_done;

	rpn_muldiv #(
		.WORD_BITS(WORD_BITS)
	) u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.unit_start),
		.is_div(op_q == OP_DIV),
		.opa   (below_q),
		.opb   (top_q),
		.done  (unit_done),
		.result(unit_res)
	);

	always_comb begin
		case (op_q)
			OP_ADD:  alu_res = below_q + top_q;
			OP_SUB:  alu_res = below_q - top_q;
			default: alu_res = unit_res;
		endcase
	end

	always_comb begin
		if (is_push && full) begin
			code_c = ST_OVER;
		end else if (is_oper && !has_two) begin
			code_c = ST_UNDER;
		end else if (is_oper && (op_q == OP_DIV) && divz) begin
			code_c = ST_DIVZ;
		end else if (is_end && empty) begin
			code_c = ST_EMPTY;
		end else begin
			code_c = ST_OK;
		end
		err_nx = (err_q == ST_OK) ? code_c : err_q;
	end

	always_comb begin
		count_nx = count_q;
		top_nx   = top_q;
		wr_en    = 1'b0;
		if (is_push && !full) begin
			count_nx = count_q + CW'(1);
			top_nx   = word_q;
			wr_en    = !empty;
		end else if (op_ok) begin
			count_nx = count_q - CW'(1);
			top_nx   = alu_res;
		end
	end

	assign rep_top    = (count_nx == '0) ? '0 : top_nx;
	assign top_wide   = {{VALUE_W{1'b0}}, rep_top};
	assign depth_wide = {{DEPTH_W{1'b0}}, count_nx};

	always_ff @(posedge clk) begin
		below_q <= stack_mem[rd_ptr[AW-1:0]];
		if (cmd.commit && wr_en) begin
			stack_mem[wr_ptr[AW-1:0]] <= top_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			err_q   <= ST_OK;
		end else if (cmd.commit) begin
			count_q <= is_end ? '0 : count_nx;
			err_q   <= is_end ? ST_OK : err_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			top_q       <= top_nx;
			top_value_q <= top_wide[VALUE_W-1:0];
			depth_q     <= depth_wide[DEPTH_W-1:0];
			status_q    <= err_nx;
			is_final_q  <= is_end;
		end
	end

	assign top_value = top_value_q;
	assign depth     = depth_q;
	assign status    = status_q;
	assign is_final  = is_final_q;

endmodule

`default_nettype wire

FILE: sv/rpn_ctrl.sv
// ----------------------------------------------------------------------------
// RPN stack evaluator controller
// Sequences one item at a time and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	output logic                   result_valid,
	input  wire logic              result_ready,
	input  wire rpn_pkg::dp_stat_t stat,
	output rpn_pkg::ctrl_cmd_t     cmd
);
	import rpn_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_ITER = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       result_valid_q;
	logic       out_free;

	assign out_free   = !result_valid_q || result_ready;
	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		state_nx       = state_q;
		cmd.cap_item   = 1'b0;
		cmd.unit_start = 1'b0;
		cmd.commit     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.cap_item = 1'b1;
					state_nx     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.need_unit) begin
					cmd.unit_start = 1'b1;
					state_nx       = S_ITER;
				end else if (out_free) begin
					cmd.commit = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			S_ITER: begin
				if (stat.unit_done) begin
					state_nx = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_nx   = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.commit) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;

endmodule

`default_nettype wire

FILE: sv/rpn_checker.sv
// ----------------------------------------------------------------------------
// RPN stack evaluator checker
// Port-level checks on item sequencing and result contents, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rpn_stack_evaluator_defines.svh"

module rpn_checker #(
	parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH
) (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               item_valid,
	input wire logic                               item_ready,
	input wire logic                               result_valid,
	input wire logic                               result_ready,
	input wire logic signed [rpn_pkg::VALUE_W-1:0] top_value,
	input wire logic [rpn_pkg::DEPTH_W-1:0]        depth,
	input wire rpn_pkg::status_t                   status,
	input wire logic                               is_final
);
	import rpn_pkg::*;

	localparam bit DEPTH_FITS = (STACK_DEPTH < (1 << DEPTH_W));

	// Items are worked one at a time.
	`RPN_ASSERT_NEXT(a_one_item, clk, arst_n, item_valid && item_ready, !item_ready, "item taken while another is in flight")

	`RPN_ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && !result_ready, result_valid && $stable(top_value) && $stable(depth) && $stable(status) && $stable(is_final), "stalled result changed")

	// An empty stack reports a zero top.
	`RPN_ASSERT_SAME(a_empty_top, clk, arst_n, result_valid && DEPTH_FITS && (depth == '0), top_value == '0, "empty stack with nonzero top")

	// Ending on an empty stack never reports success.
	`RPN_ASSERT_SAME(a_empty_end, clk, arst_n, result_valid && is_final && DEPTH_FITS && (depth == '0), status != ST_OK, "empty end reported ok")

endmodule

bind rpn_stack_evaluator rpn_checker #(
	.STACK_DEPTH(STACK_DEPTH)
) u_rpn_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_ready  (item_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.top_value   (top_value),
	.depth       (depth),
	.status      (status),
	.is_final    (is_final)
);

`default_nettype wire
